// ===== rtl/rmt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// shared constants, types and arithmetic steps of the ring mesh tessellator
package rmt_pkg;

    localparam int MAX_ANGLE_SEGMENTS  = 256;
    localparam int MAX_RADIAL_SEGMENTS = 64;

    // angles in q4.16 radians
    localparam int TWO_PI       = 411775;
    localparam int PI           = 205887;
    localparam int HALF_PI      = 102944;
    localparam int FOLD_BACK    = TWO_PI - HALF_PI;
    localparam int HALF_TURN_UP = TWO_PI - PI;

    // cordic in q2.30
    localparam int CORDIC_STEPS     = 20;
    localparam int CORDIC_PER_STAGE = 4;
    localparam int CORDIC_STAGES    = CORDIC_STEPS / CORDIC_PER_STAGE;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [33:0] ATAN [CORDIC_STEPS] = '{
        34'sd843314856, 34'sd497837829, 34'sd263043836, 34'sd133525158,
        34'sd67021686,  34'sd33543515,  34'sd16775850,  34'sd8388437,
        34'sd4194282,   34'sd2097149,   34'sd1048575,   34'sd524287,
        34'sd262143,    34'sd131071,    34'sd65535,     34'sd32767,
        34'sd16383,     34'sd8191,      34'sd4095,      34'sd2047
    };

    // row and angle step dividers
    localparam int DIV_BITS      = 32;
    localparam int DIV_PER_STAGE = 8;
    localparam int DIV_STAGES    = DIV_BITS / DIV_PER_STAGE;

    // uv divider
    localparam int TEX_MAX_STEPS = 6;
    localparam logic [16:0] TEX_ONE = 17'd65536;

    localparam int NUM_STAGES = 19;

    typedef enum logic [2:0] {
        CFG_INNER,
        CFG_OUTER,
        CFG_ANGLE_SEG,
        CFG_RADIAL_SEG,
        CFG_START,
        CFG_SWEEP
    } t_cfg_idx;

    typedef struct packed {
        logic [9:0]          rem;
        logic [DIV_BITS-1:0] quo;
    } t_div;

    typedef struct packed {
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [33:0] z;
    } t_cordic;

    typedef struct packed {
        logic        zero;
        logic        sat;
        logic [24:0] rem;
        logic [16:0] q;
    } t_tdiv;

    // everything that rides along the pipe with an item
    typedef struct packed {
        logic               valid;
        logic               act;
        logic               err;
        logic [6:0]         row;
        logic [8:0]         col;
        logic [14:0]        cor_a;
        logic [14:0]        cor_b;
        logic [14:0]        cor_c;
        logic [14:0]        cor_d;
        logic               neg_r;
        logic               neg_a;
        logic [23:0]        radius;
        logic signed [21:0] theta;
        logic [18:0]        ang;
        logic               neg;
        logic signed [24:0] pos_x;
        logic signed [24:0] pos_y;
    } t_side;

    // restoring division, one quotient bit per step
    function automatic t_div div_steps(t_div s, logic [8:0] d);
        t_div       v;
        logic [9:0] sh;
        v = s;
        for (int k = 0; k < DIV_PER_STAGE; k++) begin
            sh    = {v.rem[8:0], v.quo[DIV_BITS-1]};
            v.quo = {v.quo[DIV_BITS-2:0], 1'b0};
            if (sh >= {1'b0, d}) begin
                v.rem    = sh - {1'b0, d};
                v.quo[0] = 1'b1;
            end else begin
                v.rem = sh;
            end
        end
        return v;
    endfunction

    // a group of rotation steps starting at step first
    function automatic t_cordic cordic_steps(t_cordic s, int first);
        t_cordic            v;
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [33:0] z;
        logic signed [33:0] dx;
        logic signed [33:0] dy;
        int                 k;
        x = s.x;
        y = s.y;
        z = s.z;
        for (int n = 0; n < CORDIC_PER_STAGE; n++) begin
            k  = first + n;
            dx = y >>> k;
            dy = x >>> k;
            if (!z[33]) begin
                x = x - dx;
                y = y + dy;
                z = z - ATAN[k];
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + ATAN[k];
            end
        end
        v.x = x;
        v.y = y;
        v.z = z;
        return v;
    endfunction

    function automatic logic signed [24:0] sat_pos(logic signed [26:0] v);
        if (v > 27'sd16777215) begin
            return 25'sd16777215;
        end else if (v < -27'sd16777216) begin
            return -25'sd16777216;
        end
        return v[24:0];
    endfunction

    // first quotient bit of the uv division, plus the sign and overflow checks
    function automatic t_tdiv tex_start(logic signed [25:0] s, logic [24:0] d);
        t_tdiv v;
        v.zero = s[25] || (s == 26'sd0);
        v.sat  = ({1'b0, s[24:0]} >= {d, 1'b0});
        if (s[24:0] >= d) begin
            v.rem = s[24:0] - d;
            v.q   = 17'd1;
        end else begin
            v.rem = s[24:0];
            v.q   = 17'd0;
        end
        return v;
    endfunction

    function automatic t_tdiv tex_steps(t_tdiv s, logic [24:0] d, int count);
        t_tdiv       v;
        logic [25:0] sh;
        v = s;
        for (int n = 0; n < TEX_MAX_STEPS; n++) begin
            if (n < count) begin
                sh = {v.rem, 1'b0};
                if (sh >= {1'b0, d}) begin
                    v.rem = 25'(sh - {1'b0, d});
                    v.q   = {v.q[15:0], 1'b1};
                end else begin
                    v.rem = sh[24:0];
                    v.q   = {v.q[15:0], 1'b0};
                end
            end
        end
        return v;
    endfunction

    function automatic logic [16:0] tex_final(t_tdiv v);
        if (v.zero) begin
            return 17'd0;
        end else if (v.sat || (v.q > TEX_ONE)) begin
            return TEX_ONE;
        end
        return v.q;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/ring_mesh_tessellator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ring mesh tessellator top level: grid point in, vertex, two triangles or a range error out
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+---------------------------------------------
//  in       | i_in_valid / o_in_ready   | i_action, i_ring_row, i_ring_column
//  out      | o_out_valid / i_out_ready | o_pos_x/y, o_tex_u/v, o_corner_*, o_range_error, o_last
//  cfg      | i_cfg_we (no wait)        | i_cfg_index, i_cfg_data
//
// 19 pipeline stages plus the output register, from which each result is offered
// a vertex or an error takes one output transfer, a quad two (one per triangle); new grid points
// enter while earlier ones are in flight, but not while the output register holds a first triangle
// stages: 4 for the row and angle dividers, 5 for the cordic, 3 for the uv dividers
// synchronous reset clears the valid bits and the output valid and quad flags, and loads the configuration defaults
// a stall holds the whole pipe in place; nothing is dropped or replayed
module ring_mesh_tessellator (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [23:0]        i_cfg_data,
    // grid point requests
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_action,
    input  logic [6:0]         i_ring_row,
    input  logic [8:0]         i_ring_column,
    // results
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [24:0] o_pos_x,
    output logic signed [24:0] o_pos_y,
    output logic [16:0]        o_tex_u,
    output logic [16:0]        o_tex_v,
    output logic [14:0]        o_corner_one,
    output logic [14:0]        o_corner_two,
    output logic [14:0]        o_corner_three,
    output logic               o_range_error,
    output logic               o_last
);

    localparam int NS = rmt_pkg::NUM_STAGES;
    localparam int DS = rmt_pkg::DIV_STAGES;
    localparam int TEX_FIRST_STEPS = 5;
    localparam int TEX_MID_STEPS   = 6;
    localparam int TEX_LAST_STEPS  = 5;

    // angle wrap constants
    localparam logic signed [22:0] TP1 = 23'(rmt_pkg::TWO_PI);
    localparam logic signed [22:0] TP2 = 23'(2 * rmt_pkg::TWO_PI);
    localparam logic signed [22:0] TP3 = 23'(3 * rmt_pkg::TWO_PI);
    localparam logic signed [19:0] K_PI = 20'(rmt_pkg::PI);
    localparam logic signed [19:0] K_UP = 20'(rmt_pkg::HALF_TURN_UP);
    localparam logic signed [19:0] K_TP = 20'(rmt_pkg::TWO_PI);
    localparam logic [18:0] A_HALF = 19'(rmt_pkg::HALF_PI);
    localparam logic [18:0] A_PI   = 19'(rmt_pkg::PI);
    localparam logic [18:0] A_FOLD = 19'(rmt_pkg::FOLD_BACK);
    localparam logic signed [56:0] ROUND_HALF = 57'sd536870912;

    // configuration registers
    logic [23:0]        r_inner;
    logic [23:0]        r_outer;
    logic [8:0]         r_tseg;
    logic [6:0]         r_pseg;
    logic signed [19:0] r_start;
    logic signed [19:0] r_sweep;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inner <= 24'd32768;
            r_outer <= 24'd65536;
            r_tseg  <= 9'd32;
            r_pseg  <= 7'd1;
            r_start <= 20'sd0;
            r_sweep <= 20'sd411775;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                rmt_pkg::CFG_INNER:      r_inner <= i_cfg_data;
                rmt_pkg::CFG_OUTER:      r_outer <= i_cfg_data;
                rmt_pkg::CFG_ANGLE_SEG:  r_tseg  <= i_cfg_data[8:0];
                rmt_pkg::CFG_RADIAL_SEG: r_pseg  <= i_cfg_data[6:0];
                rmt_pkg::CFG_START:      r_start <= i_cfg_data[19:0];
                rmt_pkg::CFG_SWEEP:      r_sweep <= i_cfg_data[19:0];
                default: ;
            endcase
        end
    end

    // effective segment counts
    logic [8:0] seg_t;
    logic [6:0] seg_p;

    always_comb begin
        if (r_tseg < 9'd3) begin
            seg_t = 9'd3;
        end else if (r_tseg > 9'(rmt_pkg::MAX_ANGLE_SEGMENTS)) begin
            seg_t = 9'(rmt_pkg::MAX_ANGLE_SEGMENTS);
        end else begin
            seg_t = r_tseg;
        end
        if (r_pseg < 7'd1) begin
            seg_p = 7'd1;
        end else if (r_pseg > 7'(rmt_pkg::MAX_RADIAL_SEGMENTS)) begin
            seg_p = 7'(rmt_pkg::MAX_RADIAL_SEGMENTS);
        end else begin
            seg_p = r_pseg;
        end
    end

    // pipe enable: the whole pipe moves when the output register frees up
    logic en;
    logic r_ov;
    logic r_two;   // output holds the first triangle of a quad

    assign en         = !r_ov || (i_out_ready && !r_two);
    assign o_in_ready = en;

    rmt_pkg::t_side r_sd [1:NS];
    rmt_pkg::t_side n_sd [1:NS];

    // stage 2: range check, quad corners, dividend magnitudes
    logic               err2;
    logic [9:0]         cols;
    logic [16:0]        row_base;
    logic [14:0]        cor_a2;
    logic signed [24:0] ring_gap;
    logic signed [32:0] num_r;
    logic signed [29:0] num_a;
    logic [31:0]        mag_r;
    logic [31:0]        mag_a;

    always_comb begin
        if (r_sd[1].act) begin
            err2 = ({1'b0, r_sd[1].row} >= {1'b0, seg_p}) || (r_sd[1].col >= seg_t);
        end else begin
            err2 = (r_sd[1].row > seg_p) || (r_sd[1].col > seg_t);
        end
        cols     = {1'b0, seg_t} + 10'd1;
        row_base = r_sd[1].row * cols;
        cor_a2   = 15'(row_base + {8'b0, r_sd[1].col});
        ring_gap = $signed({1'b0, r_outer}) - $signed({1'b0, r_inner});
        num_r    = $signed({1'b0, r_sd[1].row}) * ring_gap;
        num_a    = $signed({1'b0, r_sd[1].col}) * r_sweep;
        mag_r    = num_r[32] ? 32'(-num_r) : 32'(num_r);
        mag_a    = num_a[29] ? 32'(-num_a) : 32'(num_a);
    end

    // stages 2..6: row step and angle step dividers
    rmt_pkg::t_div r_dr [0:DS];
    rmt_pkg::t_div r_da [0:DS];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dr[0].rem <= '0;
            r_dr[0].quo <= mag_r;
            r_da[0].rem <= '0;
            r_da[0].quo <= mag_a;
            for (int k = 1; k <= DS; k++) begin
                r_dr[k] <= rmt_pkg::div_steps(r_dr[k-1], {2'b0, seg_p});
                r_da[k] <= rmt_pkg::div_steps(r_da[k-1], seg_t);
            end
        end
    end

    // stage 7: radius and raw angle
    logic signed [33:0] q_r;
    logic signed [33:0] q_a;
    logic signed [33:0] rad_sum;
    logic signed [33:0] th_sum;

    always_comb begin
        q_r     = r_sd[6].neg_r ? -$signed({2'b0, r_dr[DS].quo}) : $signed({2'b0, r_dr[DS].quo});
        q_a     = r_sd[6].neg_a ? -$signed({2'b0, r_da[DS].quo}) : $signed({2'b0, r_da[DS].quo});
        rad_sum = $signed({10'b0, r_inner}) + q_r;
        th_sum  = 34'(r_start) + q_a;
    end

    // stage 8: wrap into one turn
    logic signed [22:0] th23;
    logic signed [22:0] wrap;

    always_comb begin
        th23 = 23'(r_sd[7].theta);
        if (th23 < -TP2) begin
            wrap = th23 + TP3;
        end else if (th23 < -TP1) begin
            wrap = th23 + TP2;
        end else if (th23 < 23'sd0) begin
            wrap = th23 + TP1;
        end else if (th23 < TP1) begin
            wrap = th23;
        end else if (th23 < TP2) begin
            wrap = th23 - TP1;
        end else begin
            wrap = th23 - TP2;
        end
    end

    // stage 9: fold into the right half plane, half turn flips the signs
    logic signed [19:0] a_f;
    logic               neg_f;
    logic signed [33:0] r_z;

    always_comb begin
        if (r_sd[8].ang <= A_HALF) begin
            a_f   = $signed({1'b0, r_sd[8].ang});
            neg_f = 1'b0;
        end else if (r_sd[8].ang <= A_PI) begin
            a_f   = $signed({1'b0, r_sd[8].ang}) - K_PI;
            neg_f = 1'b1;
        end else if (r_sd[8].ang < A_FOLD) begin
            a_f   = $signed({1'b0, r_sd[8].ang}) - K_UP;
            neg_f = 1'b1;
        end else begin
            a_f   = $signed({1'b0, r_sd[8].ang}) - K_TP;
            neg_f = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_z <= {a_f, 14'b0};
        end
    end

    // stages 10..14: cordic
    logic signed [33:0] cx;
    logic signed [33:0] cy;

    rmt_cordic u_cordic (
        .i_clk (i_clk),
        .i_en  (en),
        .i_z   (r_z),
        .o_x   (cx),
        .o_y   (cy)
    );

    // stage 15: radius times cosine and sine
    logic signed [33:0] cos_v;
    logic signed [33:0] sin_v;
    logic signed [56:0] r_prod_x;
    logic signed [56:0] r_prod_y;

    always_comb begin
        cos_v = r_sd[14].neg ? -cx : cx;
        sin_v = r_sd[14].neg ? -cy : cy;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_prod_x <= $signed({1'b0, r_sd[14].radius}) * $signed(cos_v[31:0]);
            r_prod_y <= $signed({1'b0, r_sd[14].radius}) * $signed(sin_v[31:0]);
        end
    end

    // stage 16: round, saturate, uv numerators
    logic signed [56:0] rnd_x;
    logic signed [56:0] rnd_y;
    logic signed [24:0] px;
    logic signed [24:0] py;
    logic signed [25:0] r_su;
    logic signed [25:0] r_sv;

    always_comb begin
        rnd_x = r_prod_x + ROUND_HALF;
        rnd_y = r_prod_y + ROUND_HALF;
        px    = rmt_pkg::sat_pos(27'(rnd_x >>> 30));
        py    = rmt_pkg::sat_pos(27'(rnd_y >>> 30));
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_su <= 26'(px) + $signed({2'b0, r_outer});
            r_sv <= 26'(py) + $signed({2'b0, r_outer});
        end
    end

    // stages 17..19: uv dividers, one quotient bit per step
    logic [24:0]    tex_den;
    rmt_pkg::t_tdiv r_tu [0:2];
    rmt_pkg::t_tdiv r_tv [0:2];

    assign tex_den = (r_outer == 24'd0) ? 25'd2 : {r_outer, 1'b0};

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tu[0] <= rmt_pkg::tex_steps(rmt_pkg::tex_start(r_su, tex_den), tex_den,
                                          TEX_FIRST_STEPS);
            r_tv[0] <= rmt_pkg::tex_steps(rmt_pkg::tex_start(r_sv, tex_den), tex_den,
                                          TEX_FIRST_STEPS);
            r_tu[1] <= rmt_pkg::tex_steps(r_tu[0], tex_den, TEX_MID_STEPS);
            r_tv[1] <= rmt_pkg::tex_steps(r_tv[0], tex_den, TEX_MID_STEPS);
            r_tu[2] <= rmt_pkg::tex_steps(r_tu[1], tex_den, TEX_LAST_STEPS);
            r_tv[2] <= rmt_pkg::tex_steps(r_tv[1], tex_den, TEX_LAST_STEPS);
        end
    end

    // sideband line; each stage fills in what it produced
    always_comb begin
        n_sd[1]       = '0;
        n_sd[1].valid = i_in_valid;
        n_sd[1].act   = i_action;
        n_sd[1].row   = i_ring_row;
        n_sd[1].col   = i_ring_column;
        for (int k = 2; k <= NS; k++) begin
            n_sd[k] = r_sd[k-1];
        end
        n_sd[2].err    = err2;
        n_sd[2].cor_a  = cor_a2;
        n_sd[2].cor_b  = 15'(cor_a2 + cols);
        n_sd[2].cor_c  = 15'(cor_a2 + cols + 10'd1);
        n_sd[2].cor_d  = 15'(cor_a2 + 15'd1);
        n_sd[2].neg_r  = num_r[32];
        n_sd[2].neg_a  = num_a[29];
        n_sd[7].radius = rad_sum[23:0];
        n_sd[7].theta  = th_sum[21:0];
        n_sd[8].ang    = wrap[18:0];
        n_sd[9].neg    = neg_f;
        n_sd[16].pos_x = px;
        n_sd[16].pos_y = py;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 1; k <= NS; k++) begin
                r_sd[k].valid <= 1'b0;
            end
        end else if (en) begin
            for (int k = 1; k <= NS; k++) begin
                r_sd[k] <= n_sd[k];
            end
        end
    end

    // output register; a quad stays two transfers, the second with b, c, d
    logic [14:0] r_cor_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov  <= 1'b0;
            r_two <= 1'b0;
        end else if (en) begin
            r_ov  <= r_sd[NS].valid;
            r_two <= r_sd[NS].valid && !r_sd[NS].err && r_sd[NS].act;
        end else if (i_out_ready && r_two) begin
            r_two <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r_sd[NS].err || r_sd[NS].act) begin
                o_pos_x <= '0;
                o_pos_y <= '0;
                o_tex_u <= '0;
                o_tex_v <= '0;
            end else begin
                o_pos_x <= r_sd[NS].pos_x;
                o_pos_y <= r_sd[NS].pos_y;
                o_tex_u <= rmt_pkg::tex_final(r_tu[2]);
                o_tex_v <= rmt_pkg::tex_final(r_tv[2]);
            end
            if (!r_sd[NS].err && r_sd[NS].act) begin
                o_corner_one   <= r_sd[NS].cor_a;
                o_corner_two   <= r_sd[NS].cor_b;
                o_corner_three <= r_sd[NS].cor_d;
            end else begin
                o_corner_one   <= '0;
                o_corner_two   <= '0;
                o_corner_three <= '0;
            end
            r_cor_c       <= r_sd[NS].cor_c;
            o_range_error <= r_sd[NS].err;
            o_last        <= r_sd[NS].err || !r_sd[NS].act;
        end else if (i_out_ready && r_two) begin
            o_corner_one <= o_corner_two;
            o_corner_two <= r_cor_c;
            o_last       <= 1'b1;
        end
    end

    assign o_out_valid = r_ov;

    // checks
    a_two_needs_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_two |-> r_ov)
        else $error("first triangle flag without a valid result");

    a_second_tri: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && r_two) |=> (o_out_valid && o_last && !r_two))
        else $error("second triangle of a quad missing");

    a_first_tri_d: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && r_two) |-> (o_corner_three == 15'(o_corner_one + 15'd1)))
        else $error("first triangle corners inconsistent");

    a_error_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_range_error) |-> (o_last && o_pos_x == 25'sd0 &&
                                           o_corner_one == 15'd0 && !r_two))
        else $error("range error result not single and clean");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("pipe held without a pending result");

endmodule
`default_nettype wire

// ===== rtl/rmt_cordic.sv =====
`timescale 1ns / 1ps
`default_nettype none
// pipelined rotation-mode cordic giving cosine and sine of a q2.30 angle
module rmt_cordic (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [33:0] i_z,
    output logic signed [33:0] o_x,
    output logic signed [33:0] o_y
);

    rmt_pkg::t_cordic r_st [rmt_pkg::CORDIC_STAGES];
    rmt_pkg::t_cordic seed;

    always_comb begin
        seed.x = rmt_pkg::CORDIC_GAIN;
        seed.y = '0;
        seed.z = i_z;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st[0] <= rmt_pkg::cordic_steps(seed, 0);
            for (int s = 1; s < rmt_pkg::CORDIC_STAGES; s++) begin
                r_st[s] <= rmt_pkg::cordic_steps(r_st[s-1], s * rmt_pkg::CORDIC_PER_STAGE);
            end
        end
    end

    assign o_x = r_st[rmt_pkg::CORDIC_STAGES-1].x;
    assign o_y = r_st[rmt_pkg::CORDIC_STAGES-1].y;

endmodule
`default_nettype wire

// ===== tb/sv/ring_mesh_tessellator_test.sv =====
`timescale 1ns / 1ps
// testbench for the ring mesh tessellator: directed and random grid requests against a fixed-point predictor
module ring_mesh_tessellator_test;

    // grid request as it waits in the send queue
    typedef struct {
        logic       act;
        logic [6:0] row;
        logic [8:0] col;
    } t_grid_req;

    // one vertex, triangle or error result
    typedef struct {
        logic signed [24:0] px;
        logic signed [24:0] py;
        logic [16:0]        u;
        logic [16:0]        v;
        logic [14:0]        c1;
        logic [14:0]        c2;
        logic [14:0]        c3;
        logic               err;
        logic               last;
    } t_mesh_out;

    localparam int IDLE_LIMIT = 4000;
    localparam int DRAIN      = 30;

    localparam longint ARCTAN [20] = '{
        843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
        16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
        131071, 65535, 32767, 16383, 8191, 4095, 2047
    };

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [2:0]         i_cfg_index = 3'd0;
    logic [23:0]        i_cfg_data = 24'd0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic               i_action = 1'b0;
    logic [6:0]         i_ring_row = 7'd0;
    logic [8:0]         i_ring_column = 9'd0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic signed [24:0] o_pos_x;
    logic signed [24:0] o_pos_y;
    logic [16:0]        o_tex_u;
    logic [16:0]        o_tex_v;
    logic [14:0]        o_corner_one;
    logic [14:0]        o_corner_two;
    logic [14:0]        o_corner_three;
    logic               o_range_error;
    logic               o_last;

    // model copy of the registers, reset values
    logic [23:0] inner_r = 24'd32768;
    logic [23:0] outer_r = 24'd65536;
    logic [8:0]  tseg_r = 9'd32;
    logic [6:0]  pseg_r = 7'd1;
    logic [19:0] start_r = 20'd0;
    logic [19:0] sweep_r = 20'd411775;

    t_grid_req grid_queue[$];
    t_mesh_out mesh_expected[$];
    t_grid_req on_wire;
    int        mismatches = 0;
    int        idle_cycles = 0;
    int        burst_left = 0;
    int        gap_left = 0;
    int        rx_window = 0;
    int        rx_mode = 0;

    ring_mesh_tessellator dut (.*);

    always #10 i_clk = ~i_clk;

    // effective segment counts after clamping
    function automatic longint eff_t();
        longint t;
        t = longint'(tseg_r);
        if (t < 3) t = 3;
        if (t > rmt_pkg::MAX_ANGLE_SEGMENTS) t = rmt_pkg::MAX_ANGLE_SEGMENTS;
        return t;
    endfunction

    function automatic longint eff_p();
        longint p;
        p = longint'(pseg_r);
        if (p < 1) p = 1;
        if (p > rmt_pkg::MAX_RADIAL_SEGMENTS) p = rmt_pkg::MAX_RADIAL_SEGMENTS;
        return p;
    endfunction

    // cos and sin in q2.30 by 20 cordic steps after folding into [-pi/2, pi/2]
    task automatic rotate(input longint theta, output longint c, output longint s);
        longint a;
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        bit     flip;
        flip = 0;
        a = theta % 411775;
        if (a < 0) a += 411775;
        if (a > 205887) a -= 411775;
        if (a > 102944) begin
            a -= 205887;
            flip = 1;
        end else if (a < -102944) begin
            a += 205887;
            flip = 1;
        end
        x = 652032874;
        y = 0;
        z = a * 16384;
        for (int k = 0; k < 20; k++) begin
            dx = y >>> k;
            dy = x >>> k;
            if (z >= 0) begin
                x -= dx;
                y += dy;
                z -= ARCTAN[k];
            end else begin
                x += dx;
                y -= dy;
                z += ARCTAN[k];
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    function automatic longint clamp_pos(longint v);
        if (v > 16777215) return 16777215;
        if (v < -16777216) return -16777216;
        return v;
    endfunction

    // uv = (coord/outer + 1)/2, saturated, with a zero outer radius dividing by 2
    function automatic logic [16:0] uv_of(longint p, longint outer);
        longint num;
        longint den;
        longint q;
        num = (p + outer) * 65536;
        den = outer > 0 ? 2 * outer : 2;
        if (num <= 0) return 17'd0;
        q = num / den;
        return q > 65536 ? 17'd65536 : 17'(q);
    endfunction

    // expected results of one grid request under the current registers
    task automatic predict_mesh(input t_grid_req rq);
        t_mesh_out o;
        longint    t;
        longint    p;
        longint    r;
        longint    th;
        longint    c;
        longint    s;
        longint    x;
        longint    y;
        longint    a;
        t = eff_t();
        p = eff_p();
        o = '{default: '0};
        if (rq.act ? (rq.row >= p || rq.col >= t) : (rq.row > p || rq.col > t)) begin
            o.err = 1'b1;
            o.last = 1'b1;
            mesh_expected.push_back(o);
        end else if (!rq.act) begin
            r = longint'(inner_r) +
                (longint'(rq.row) * (longint'(outer_r) - longint'(inner_r))) / p;
            th = longint'($signed(start_r)) + (longint'(rq.col) * longint'($signed(sweep_r))) / t;
            rotate(th, c, s);
            x = clamp_pos((r * c + (64'sd1 <<< 29)) >>> 30);
            y = clamp_pos((r * s + (64'sd1 <<< 29)) >>> 30);
            o.px = 25'(x);
            o.py = 25'(y);
            o.u = uv_of(x, longint'(outer_r));
            o.v = uv_of(y, longint'(outer_r));
            o.last = 1'b1;
            mesh_expected.push_back(o);
        end else begin
            // triangles (a,b,d) then (b,c,d)
            a = longint'(rq.row) * (t + 1) + longint'(rq.col);
            o.c1 = 15'(a);
            o.c2 = 15'(a + t + 1);
            o.c3 = 15'(a + 1);
            mesh_expected.push_back(o);
            o.c1 = 15'(a + t + 1);
            o.c2 = 15'(a + t + 2);
            o.last = 1'b1;
            mesh_expected.push_back(o);
        end
    endtask

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // sender: bursts of transfers with random gaps between them
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                predict_mesh(on_wire);
            end
            if (!i_in_valid || o_in_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (grid_queue.size() > 0) begin
                    on_wire = grid_queue.pop_front();
                    i_action <= on_wire.act;
                    i_ring_row <= on_wire.row;
                    i_ring_column <= on_wire.col;
                    i_in_valid <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: random stall pattern, picked anew each time rx_window wraps
    always @(posedge i_clk) begin
        if (rx_window == 0) begin
            rx_mode = $urandom_range(0, 3);
        end
        rx_window = (rx_window + 1) % 64;
        case (rx_mode)
            0: i_out_ready <= 1'b1;
            1: i_out_ready <= 1'($urandom_range(0, 1));
            2: i_out_ready <= ($urandom_range(0, 7) == 0);
            default: i_out_ready <= (rx_window[3:0] < 4'd10);
        endcase
    end

    // monitor: compare each result transfer with the oldest expectation
    always @(posedge i_clk) begin
        t_mesh_out w;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (mesh_expected.size() == 0) begin
                report("unexpected result", 0, 0);
            end else begin
                w = mesh_expected.pop_front();
                if (o_pos_x !== w.px) report("pos_x", o_pos_x, w.px);
                if (o_pos_y !== w.py) report("pos_y", o_pos_y, w.py);
                if (o_tex_u !== w.u) report("tex_u", o_tex_u, w.u);
                if (o_tex_v !== w.v) report("tex_v", o_tex_v, w.v);
                if (o_corner_one !== w.c1) report("corner_one", o_corner_one, w.c1);
                if (o_corner_two !== w.c2) report("corner_two", o_corner_two, w.c2);
                if (o_corner_three !== w.c3) report("corner_three", o_corner_three, w.c3);
                if (o_range_error !== w.err) report("range_error", o_range_error, w.err);
                if (o_last !== w.last) report("last", o_last, w.last);
            end
        end
    end

    // watchdog on cycles without any transfer or register write
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || i_cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("ring_mesh_tessellator_test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // all six registers in consecutive cycles, only while idle
    task automatic load_regs(input logic [23:0] inner, input logic [23:0] outer,
                             input logic [8:0] tseg, input logic [6:0] pseg,
                             input logic [19:0] start, input logic [19:0] sweep);
        logic [23:0]       vals [6];
        rmt_pkg::t_cfg_idx idx [6];
        vals = '{inner, outer, 24'(tseg), 24'(pseg), 24'(start), 24'(sweep)};
        idx = '{rmt_pkg::CFG_INNER, rmt_pkg::CFG_OUTER, rmt_pkg::CFG_ANGLE_SEG,
                rmt_pkg::CFG_RADIAL_SEG, rmt_pkg::CFG_START, rmt_pkg::CFG_SWEEP};
        @(posedge i_clk);
        for (int k = 0; k < 6; k++) begin
            i_cfg_we <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data <= vals[k];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        inner_r = inner;
        outer_r = outer;
        tseg_r = tseg;
        pseg_r = pseg;
        start_r = start;
        sweep_r = sweep;
    endtask

    task automatic queue_req(input logic act, input logic [6:0] row, input logic [8:0] col);
        t_grid_req rq;
        rq.act = act;
        rq.row = row;
        rq.col = col;
        grid_queue.push_back(rq);
    endtask

    // mostly points inside the grid or just past its edge, some anywhere in the field range
    task automatic queue_random(input int count);
        int pmax;
        int tmax;
        pmax = int'(eff_p()) + 1;
        tmax = int'(eff_t()) + 1;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 9) == 0) begin
                queue_req(1'($urandom_range(0, 1)), 7'($urandom_range(0, 127)),
                          9'($urandom_range(0, 511)));
            end else begin
                queue_req(1'($urandom_range(0, 1)), 7'($urandom_range(0, pmax)),
                          9'($urandom_range(0, tmax)));
            end
        end
    endtask

    // let everything drain, then wait out the DRAIN margin before the next register write
    task automatic drain_all();
        while (grid_queue.size() > 0 || i_in_valid || mesh_expected.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN) @(posedge i_clk);
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: grid edges, out of range and field extremes
        queue_req(1'b0, 7'd0, 9'd0);
        queue_req(1'b0, 7'd1, 9'd32);
        queue_req(1'b0, 7'd1, 9'd16);
        queue_req(1'b0, 7'd2, 9'd0);
        queue_req(1'b0, 7'd0, 9'd33);
        queue_req(1'b0, 7'd127, 9'd511);
        queue_req(1'b1, 7'd0, 9'd0);
        queue_req(1'b1, 7'd0, 9'd31);
        queue_req(1'b1, 7'd1, 9'd0);
        queue_req(1'b1, 7'd0, 9'd32);
        queue_req(1'b1, 7'd127, 9'd511);
        queue_random(150);
        drain_all();

        // largest grid, widest radius span, full negative start
        load_regs(24'd0, 24'hFFFFFF, 9'd256, 7'd64, 20'(-411775), 20'd411775);
        queue_req(1'b0, 7'd64, 9'd256);
        queue_req(1'b1, 7'd63, 9'd255);
        queue_req(1'b0, 7'd64, 9'd0);
        queue_req(1'b1, 7'd64, 9'd0);
        queue_random(170);
        drain_all();

        // counts below the minimum, inner beyond outer, reversed sweep
        load_regs(24'hFFFFFF, 24'd1, 9'd0, 7'd0, 20'd411775, 20'(-411775));
        queue_req(1'b0, 7'd1, 9'd3);
        queue_req(1'b1, 7'd0, 9'd2);
        queue_random(170);
        drain_all();

        // zero outer radius
        load_regs(24'd40000, 24'd0, 9'd2, 7'd3, 20'd100000, 20'd300000);
        queue_random(150);
        drain_all();

        // counts above the maximum saturate
        load_regs(24'd70000, 24'd900000, 9'd511, 7'd127, 20'(-205887), 20'd205887);
        queue_req(1'b0, 7'd64, 9'd256);
        queue_req(1'b1, 7'd63, 9'd255);
        queue_req(1'b0, 7'd65, 9'd257);
        queue_random(150);
        drain_all();

        // random settings
        for (int ph = 0; ph < 3; ph++) begin
            load_regs(24'($urandom_range(0, 24'hFFFFFF)), 24'($urandom_range(1, 24'hFFFFFF)),
                      9'($urandom_range(0, 300)), 7'($urandom_range(0, 70)),
                      20'($signed($urandom_range(0, 823550)) - 411775),
                      20'($signed($urandom_range(0, 823550)) - 411775));
            queue_random(120);
            drain_all();
        end

        if (mismatches == 0) begin
            $display("ring_mesh_tessellator_test passed");
        end else begin
            $display("ring_mesh_tessellator_test failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/rmt_pkg.sv
rtl/rmt_cordic.sv
rtl/ring_mesh_tessellator.sv
tb/sv/ring_mesh_tessellator_test.sv
